// ===== sv/ksa_pkg.sv =====
// ----------------------------------------------------------------------------
// ksa_pkg: shared types and codes of the keyed slot allocator.
// Field widths, request kinds, result status codes and the tag table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package ksa_pkg;

  // Widths of the transaction fields.
  localparam int ID_W       = 4;
  localparam int KEY_W      = 64;
  localparam int SLOT_NUM_W = 6;
  localparam int STATUS_W   = 3;

  // Request kinds.
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_FREE   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd4;

  // One tag table entry; entry i describes slot i.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] rep;
    logic [ID_W-1:0] org;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/ksa_ram.sv =====
// ----------------------------------------------------------------------------
// ksa_ram: generic simple dual-port RAM.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ksa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/keyed_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_allocator: tag table with a free-list slot allocator.
// The sequential tag scan reads one entry per cycle from the table RAM, from
// slot 0 upward, and stops at the first match or after the last slot.
// One request at a time.
// Reset: a clearing pass over every slot clears the table and loads the free
// FIFO with slots 0 to SLOTS-1; no request is accepted during it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  wire         clk,
  input  wire         rst,
  // Request channel.
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         kind,
  input  wire  [3:0]  replayer_id,
  input  wire  [3:0]  origin_id,
  input  wire  [63:0] msg_index,
  // Result channel.
  output logic        out_valid,
  input  wire         out_stall,
  output logic [5:0]  slot_number,
  output logic [2:0]  status
);

  // Slot index width, and the FIFO occupancy width, which must hold SLOTS.
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int NUM_W  = ksa_pkg::SLOT_NUM_W;
  localparam int ENT_W  = $bits(ksa_pkg::entry_t);

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(SLOTS);

  // Sequencer states.
  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;

  // Clearing pass address after reset.
  logic [SLOT_W-1:0] clr_idx;

  // The request being served.
  logic                          op_kind;
  logic [ksa_pkg::ID_W-1:0]      op_rep;
  logic [ksa_pkg::ID_W-1:0]      op_org;
  logic [ksa_pkg::KEY_W-1:0]     op_key;

  // Tag scan: scan_idx is the address issued to the table RAM this cycle,
  // cmp_idx is the address whose data arrives this cycle.
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] cmp_idx;
  logic              cmp_valid;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;

  // Free FIFO pointers and occupancy.
  logic [SLOT_W-1:0] fifo_head;
  logic [SLOT_W-1:0] fifo_tail;
  logic [CNT_W-1:0]  fifo_count;

  // RAM ports.
  ksa_pkg::entry_t   ent_rdata;
  ksa_pkg::entry_t   ent_wdata;
  logic              ent_we;
  logic [SLOT_W-1:0] ent_waddr;
  logic [SLOT_W-1:0] fifo_rdata;
  logic [SLOT_W-1:0] fifo_wdata;
  logic              fifo_we;
  logic [SLOT_W-1:0] fifo_waddr;

  // Decision logic.
  logic              match;
  logic              out_free;
  logic              finish_go;
  logic              fifo_empty;
  logic              do_alloc;
  logic              do_release;
  logic              do_push;
  logic [SLOT_W-1:0] res_slot;
  logic [2:0]        res_status;

  // The table holds the valid flag, the two ids and the key of each slot.
  // The clearing pass after reset zeroes every entry, so the valid flags live
  // in the RAM alongside the tags and need no flip-flop per slot.
  ksa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (scan_idx),
    .rdata (ent_rdata)
  );

  // The free FIFO storage. Its read port always looks at the head; the head
  // moves only when a request finishes, and the idle state and the next scan
  // come before it is used again, so the registered head data is always current.
  ksa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_free_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (fifo_head),
    .rdata (fifo_rdata)
  );

  // A request is taken only when the sequencer is idle.
  assign in_stall = (state != S_IDLE);

  // The entry that arrives from the table matches when it is valid and its
  // ids and key equal the request's.
  assign match = ent_rdata.valid && (ent_rdata.rep == op_rep) &&
                 (ent_rdata.org == op_org) && (ent_rdata.key == op_key);

  // The result register is free when empty or being emptied this cycle.
  // A request finishes only then; its table and FIFO updates happen in that
  // same cycle, before the next request can start its scan, so no read of
  // the table ever overlaps a pending write to the same entry.
  assign out_free   = !out_valid || !out_stall;
  assign finish_go  = (state == S_FINISH) && out_free;
  assign fifo_empty = (fifo_count == '0);
  assign do_alloc   = finish_go && (op_kind == ksa_pkg::KIND_LOOKUP) && !hit && !fifo_empty;
  assign do_release = finish_go && (op_kind == ksa_pkg::KIND_FREE) && hit;
  assign do_push    = do_release && (fifo_count != FULL_COUNT);

  // Result of the request held in the sequencer.
  always_comb begin
    res_slot   = '0;
    res_status = ksa_pkg::ST_MISS;
    if (op_kind == ksa_pkg::KIND_LOOKUP) begin
      if (hit) begin
        res_slot   = hit_slot;
        res_status = ksa_pkg::ST_HIT;
      end else if (fifo_empty) begin
        res_status = ksa_pkg::ST_FULL;
      end else begin
        res_slot   = fifo_rdata;
        res_status = ksa_pkg::ST_NEW;
      end
    end else if (hit) begin
      res_slot   = hit_slot;
      res_status = ksa_pkg::ST_FREED;
    end
  end

  // Table writes: zero during the clearing pass, bind on an allocation,
  // drop the valid flag on a release.
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = clr_idx;
    ent_wdata = '0;
    if (state == S_CLEAR) begin
      ent_we = 1'b1;
    end else if (do_alloc) begin
      ent_we          = 1'b1;
      ent_waddr       = fifo_rdata;
      ent_wdata.valid = 1'b1;
      ent_wdata.rep   = op_rep;
      ent_wdata.org   = op_org;
      ent_wdata.key   = op_key;
    end else if (do_release) begin
      ent_we    = 1'b1;
      ent_waddr = hit_slot;
    end
  end

  // FIFO writes: slot i into place i during the clearing pass, and the
  // released slot onto the tail.
  always_comb begin
    fifo_we    = 1'b0;
    fifo_waddr = clr_idx;
    fifo_wdata = clr_idx;
    if (state == S_CLEAR) begin
      fifo_we = 1'b1;
    end else if (do_push) begin
      fifo_we    = 1'b1;
      fifo_waddr = fifo_tail;
      fifo_wdata = hit_slot;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      cmp_valid  <= 1'b0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= FULL_COUNT;
      out_valid  <= 1'b0;
    end else begin
      // A taken result clears the flag unless a new result replaces it in
      // the same cycle.
      if (out_valid && !out_stall && !finish_go) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= (clr_idx == LAST_SLOT) ? '0 : clr_idx + 1'b1;
          if (clr_idx == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            op_kind   <= kind;
            op_rep    <= replayer_id;
            op_org    <= origin_id;
            op_key    <= msg_index;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Issue the next address while comparing the previous one. The
          // lowest matching slot wins because the scan runs upward and stops
          // at the first match.
          scan_idx  <= (scan_idx == LAST_SLOT) ? '0 : scan_idx + 1'b1;
          cmp_idx   <= scan_idx;
          cmp_valid <= 1'b1;
          if (cmp_valid && (match || (cmp_idx == LAST_SLOT))) begin
            hit      <= match;
            hit_slot <= cmp_idx;
            state    <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            slot_number <= NUM_W'(res_slot);
            status      <= res_status;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // FIFO pointer and occupancy updates.
      if (do_alloc) begin
        fifo_head <= (fifo_head == LAST_SLOT) ? '0 : fifo_head + 1'b1;
      end
      if (do_push) begin
        fifo_tail <= (fifo_tail == LAST_SLOT) ? '0 : fifo_tail + 1'b1;
      end
      if (do_alloc && !do_push) begin
        fifo_count <= fifo_count - 1'b1;
      end else if (do_push && !do_alloc) begin
        fifo_count <= fifo_count + 1'b1;
      end
    end
  end

  // The FIFO never holds more slots than exist.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FULL_COUNT)
    else $error("free FIFO occupancy exceeds the slot count");

  // A result appears only when a request finishes.
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result transaction without a finished request");

  // A new binding takes exactly one slot from the FIFO.
  a_alloc_pops : assert property (@(posedge clk) disable iff (rst)
    (finish_go && res_status == ksa_pkg::ST_NEW) |=>
      fifo_count == $past(fifo_count) - 1'b1)
    else $error("allocation did not pop the free FIFO");

  // No request is taken until the clearing pass is done.
  a_clear_blocks : assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall && !out_valid)
    else $error("activity during the clearing pass");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keyed slot allocator.
// A queue of requests, directed ones first and then random ones, feeds a
// clocked driver. Each accepted request goes through a slot table and free
// ring model of the bench's own, which predicts the slot and status that
// the block must return. A clocked monitor compares every returned
// transaction with the oldest prediction. Both sides idle at random, and
// once the result side holds off long enough to back the block up.
// ----------------------------------------------------------------------------

module testbench;

  localparam int SLOT_COUNT = 64;
  localparam int RANDOM_REQUESTS = 700;
  // The result side holds off for a long stretch once this many results
  // have been taken, so that the block fills up and stalls its request side.
  localparam int LONG_HOLD_AT = 200;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct {
    logic                      kind;
    logic [ksa_pkg::ID_W-1:0]  rep;
    logic [ksa_pkg::ID_W-1:0]  org;
    logic [ksa_pkg::KEY_W-1:0] key;
  } request_t;

  typedef struct {
    logic [ksa_pkg::SLOT_NUM_W-1:0] slot;
    logic [ksa_pkg::STATUS_W-1:0]   status;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic             kind        = ksa_pkg::KIND_LOOKUP;
  logic [3:0]       replayer_id = '0;
  logic [3:0]       origin_id   = '0;
  logic [63:0]      msg_index   = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [5:0]       slot_number;
  logic [2:0]       status;

  keyed_slot_allocator #(.SLOTS(SLOT_COUNT)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .replayer_id (replayer_id),
    .origin_id   (origin_id),
    .msg_index   (msg_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_number (slot_number),
    .status      (status)
  );

  always #5 clk = ~clk;

  // Requests still to be driven, and the grants predicted for the requests
  // that the block has taken but not yet answered.
  request_t requests_to_send[$];
  grant_t   grants_due[$];

  int total_requests    = 0;
  int requests_loaded   = 0;
  int requests_accepted = 0;
  int results_seen      = 0;
  int mismatches        = 0;

  // Model of the slot table and the free ring. Entry i describes slot i.
  logic                           slot_bound[SLOT_COUNT];
  logic [ksa_pkg::ID_W-1:0]       slot_rep[SLOT_COUNT];
  logic [ksa_pkg::ID_W-1:0]       slot_org[SLOT_COUNT];
  logic [ksa_pkg::KEY_W-1:0]      slot_key[SLOT_COUNT];
  logic [ksa_pkg::SLOT_NUM_W-1:0] free_ring[SLOT_COUNT];
  int ring_head;
  int ring_tail;
  int ring_count;

  // Keys that the stimulus believes are bound right now. This mirror only
  // steers the random mix toward hits and real frees; it never predicts.
  request_t bound_keys[$];

  // Works out the grant for one request and updates the model. The lowest
  // bound slot with a matching key wins. A miss on an empty ring and a free
  // of an unbound key both leave the model as it was and report slot zero.
  task automatic predict_grant(input request_t rq, output grant_t g);
    int hit;
    int slot;
    hit = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_bound[i] && slot_rep[i] == rq.rep && slot_org[i] == rq.org &&
          slot_key[i] == rq.key) begin
        hit = i;
      end
    end
    g.slot = '0;
    if (rq.kind == ksa_pkg::KIND_LOOKUP) begin
      if (hit >= 0) begin
        g.slot = hit[ksa_pkg::SLOT_NUM_W-1:0];
        g.status = ksa_pkg::ST_HIT;
      end else if (ring_count == 0) begin
        g.status = ksa_pkg::ST_FULL;
      end else begin
        slot = free_ring[ring_head];
        ring_head = (ring_head + 1) % SLOT_COUNT;
        ring_count--;
        slot_bound[slot] = 1'b1;
        slot_rep[slot] = rq.rep;
        slot_org[slot] = rq.org;
        slot_key[slot] = rq.key;
        g.slot = slot[ksa_pkg::SLOT_NUM_W-1:0];
        g.status = ksa_pkg::ST_NEW;
      end
    end else begin
      if (hit >= 0) begin
        slot_bound[hit] = 1'b0;
        if (ring_count < SLOT_COUNT) begin
          free_ring[ring_tail] = hit[ksa_pkg::SLOT_NUM_W-1:0];
          ring_tail = (ring_tail + 1) % SLOT_COUNT;
          ring_count++;
        end
        g.slot = hit[ksa_pkg::SLOT_NUM_W-1:0];
        g.status = ksa_pkg::ST_FREED;
      end else begin
        g.status = ksa_pkg::ST_MISS;
      end
    end
  endtask

  // Idle cycles after one transaction. Every fourth stretch of fifty
  // transactions runs with no idling at all.
  function automatic int draw_wait(input int n);
    if ((n / 50) % 4 == 3) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic int find_bound(input request_t rq);
    foreach (bound_keys[i]) begin
      if (bound_keys[i].rep == rq.rep && bound_keys[i].org == rq.org &&
          bound_keys[i].key == rq.key) return i;
    end
    return -1;
  endfunction

  // Queues one request and keeps the stimulus mirror of bound keys current.
  task automatic queue_request(input logic k, input logic [3:0] r, input logic [3:0] o,
                               input logic [63:0] key);
    request_t rq;
    int at;
    rq.kind = k;
    rq.rep = r;
    rq.org = o;
    rq.key = key;
    at = find_bound(rq);
    if (k == ksa_pkg::KIND_LOOKUP) begin
      if (at < 0 && bound_keys.size() < SLOT_COUNT) bound_keys.push_back(rq);
    end else if (at >= 0) begin
      bound_keys.delete(at);
    end
    requests_to_send.push_back(rq);
    total_requests++;
  endtask

  // A bound key with one bit of its index or of one id flipped.
  function automatic request_t near_miss(input request_t rq);
    request_t m;
    m = rq;
    case ($urandom_range(0, 2))
      0: m.key[$urandom_range(0, ksa_pkg::KEY_W - 1)] ^= 1'b1;
      1: m.rep[$urandom_range(0, ksa_pkg::ID_W - 1)] ^= 1'b1;
      default: m.org[$urandom_range(0, ksa_pkg::ID_W - 1)] ^= 1'b1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] extreme_key();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'h8000_0000_0000_0000;
      default: return '1;
    endcase
  endfunction

  // Stimulus, then the end-of-run decision.
  initial begin
    request_t pick;
    request_t alt;
    int r;
    logic fill_phase;

    foreach (slot_bound[i]) begin
      slot_bound[i] = 1'b0;
      slot_rep[i] = '0;
      slot_org[i] = '0;
      slot_key[i] = '0;
      free_ring[i] = i[ksa_pkg::SLOT_NUM_W-1:0];
    end
    ring_head = 0;
    ring_tail = 0;
    ring_count = SLOT_COUNT;

    // Directed part: extremes of the ids and of the index, a hit, a free,
    // a free of an unbound key, keys that differ only in which id is which,
    // and reuse of a freed slot in ring order.
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd0, 4'd0, 64'd0);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd0, 4'd0, 64'd0);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd15, 4'd15, '1);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd15, 4'd0, '1);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd0, 4'd15, '1);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd5, 4'd5, 64'h8000_0000_0000_0000);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd5, 4'd5, 64'h0000_0000_0000_0001);
    queue_request(ksa_pkg::KIND_FREE, 4'd15, 4'd15, '1);
    queue_request(ksa_pkg::KIND_FREE, 4'd15, 4'd15, '1);
    queue_request(ksa_pkg::KIND_FREE, 4'd0, 4'd0, 64'd1);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd0, 4'd15, '1);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd15, 4'd15, '1);
    queue_request(ksa_pkg::KIND_FREE, 4'd0, 4'd0, 64'd0);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd10, 4'd3, 64'hAAAA_5555_AAAA_5555);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd3, 4'd10, 64'h5555_AAAA_5555_AAAA);
    queue_request(ksa_pkg::KIND_FREE, 4'd3, 4'd10, 64'hAAAA_5555_AAAA_5555);
    queue_request(ksa_pkg::KIND_LOOKUP, 4'd0, 4'd0, 64'd0);
    queue_request(ksa_pkg::KIND_FREE, 4'd5, 4'd5, 64'h0000_0000_0000_0001);

    // Random part. Stretches that mostly allocate alternate with stretches
    // that mostly free, so the ring runs dry and refills several times.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      fill_phase = ((n / 120) % 2 == 0);
      r = $urandom_range(0, 99);
      if (bound_keys.size() == 0 && r >= 15 && r < 95) r = 0;
      if (bound_keys.size() != 0) pick = bound_keys[$urandom_range(0, bound_keys.size() - 1)];
      if (r < (fill_phase ? 50 : 15)) begin
        queue_request(ksa_pkg::KIND_LOOKUP, 4'($urandom), 4'($urandom),
                      {$urandom, $urandom});
      end else if (r < (fill_phase ? 75 : 40)) begin
        queue_request(ksa_pkg::KIND_LOOKUP, pick.rep, pick.org, pick.key);
      end else if (r < (fill_phase ? 85 : 80)) begin
        queue_request(ksa_pkg::KIND_FREE, pick.rep, pick.org, pick.key);
      end else if (r < 90) begin
        alt = near_miss(pick);
        queue_request(ksa_pkg::KIND_FREE, alt.rep, alt.org, alt.key);
      end else if (r < 95) begin
        alt = near_miss(pick);
        queue_request(ksa_pkg::KIND_LOOKUP, alt.rep, alt.org, alt.key);
      end else begin
        queue_request(1'($urandom), $urandom_range(0, 1) ? 4'd15 : 4'd0,
                      $urandom_range(0, 1) ? 4'd15 : 4'd0, extreme_key());
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (requests_accepted == total_requests);
    wait (results_seen >= requests_accepted);
    // A scan of the whole table is the longest the block can still be busy.
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Request driver. The prediction is made at the edge where the block
  // takes a transaction, so the model sees requests in acceptance order.
  always @(posedge clk) begin : drive_requests
    grant_t g;
    request_t on_wire;
    int send_wait;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_grant(on_wire, g);
        grants_due.push_back(g);
        requests_accepted++;
      end
      // The channel is free when nothing is offered or the offer was taken.
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
          on_wire = requests_to_send.pop_front();
          kind <= on_wire.kind;
          replayer_id <= on_wire.rep;
          origin_id <= on_wire.org;
          msg_index <= on_wire.key;
          in_valid <= 1'b1;
          send_wait = draw_wait(requests_loaded);
          requests_loaded++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. After each taken transaction it stalls for a drawn
  // number of cycles, counted here whether or not a result is waiting.
  always @(posedge clk) begin : check_results
    grant_t want;
    int stall_left;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (grants_due.size() == 0) begin
          $display("%0t: result with none expected: slot %0d status %0d",
                   $time, slot_number, status);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          if (slot_number !== want.slot) begin
            $display("%0t: slot_number expected %0d actual %0d",
                     $time, want.slot, slot_number);
            mismatches++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
        end
        stall_left = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                     : draw_wait(results_seen);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Hard limit, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
